// File: src/h2f_pkg.sv
// Package: shared constants and types of the 2x2 Haar feature extractor.
`default_nettype none
package h2f_pkg;
	localparam int unsigned MAX_WIDTH    = 64;
	localparam int unsigned HEIGHT_LIMIT = 64;
	localparam int unsigned ADDR_W       = $clog2(MAX_WIDTH);
	localparam int unsigned CNT_W        = 6;
	localparam int unsigned DIM_W        = 7;
	localparam int unsigned PIX_W        = 8;
	localparam int unsigned WIN_COLS     = 2;

	localparam logic [DIM_W-1:0] WIDTH_RESET  = 7'd19;
	localparam logic [DIM_W-1:0] HEIGHT_RESET = 7'd19;
	localparam logic [DIM_W-1:0] DIM_MIN      = 7'd2;

	typedef enum logic {
		CFG_FRAME_WIDTH  = 1'b0,
		CFG_FRAME_HEIGHT = 1'b1
	} cfg_idx_t;

	// One column of the 2x2 window: pixel of the row above and of the current row.
	typedef struct packed {
		logic [PIX_W-1:0] top;
		logic [PIX_W-1:0] bottom;
	} pix_pair_t;
endpackage
`default_nettype wire

// File: src/h2f_if.sv
// Interfaces: pixel input channel and feature output channel.
`default_nettype none
interface h2f_pixel_if;
	logic       valid;
	logic       ready;
	logic [7:0] pixel;

	modport source (output valid, output pixel, input ready);
	modport sink (input valid, input pixel, output ready);
endinterface

interface h2f_feat_if;
	logic              valid;
	logic              ready;
	logic signed [8:0] diff_right;
	logic signed [8:0] diff_down;
	logic signed [9:0] diff_diagonal;
	logic [5:0]        anchor_row;
	logic [5:0]        anchor_col;
	logic              last_of_frame;

	modport source (output valid, output diff_right, output diff_down,
		output diff_diagonal, output anchor_row, output anchor_col,
		output last_of_frame, input ready);
	modport sink (input valid, input diff_right, input diff_down,
		input diff_diagonal, input anchor_row, input anchor_col,
		input last_of_frame, output ready);
endinterface
`default_nettype wire

// File: src/h2f_col_cell.sv
// Window column cell: holds one vertical pixel pair and passes it on when advanced.
`default_nettype none
module h2f_col_cell (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                advance,
	input  h2f_pkg::pix_pair_t pair_in,
	output h2f_pkg::pix_pair_t pair_q
);
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pair_q <= '0;
		end else if (advance) begin
			pair_q <= pair_in;
		end
	end
endmodule
`default_nettype wire

// File: src/h2f_line_buf.sv
// Line buffer: one row of pixels, one write and one registered read per cycle.
`default_nettype none
module h2f_line_buf (
	input  wire                              clk,
	input  wire                              wr_en,
	input  wire  [h2f_pkg::ADDR_W-1:0]       wr_addr,
	input  wire  [h2f_pkg::PIX_W-1:0]        wr_data,
	input  wire                              rd_en,
	input  wire  [h2f_pkg::ADDR_W-1:0]       rd_addr,
	output logic [h2f_pkg::PIX_W-1:0]        rd_data_q
);
	logic [h2f_pkg::PIX_W-1:0] mem_q [h2f_pkg::MAX_WIDTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end
endmodule
`default_nettype wire

// File: src/haar_2x2_feature_extractor_top.sv
// Top level: 2x2 Haar-like feature extractor over a raster pixel stream.
//
//   channel | dir | handshake          | payload
//   --------+-----+--------------------+------------------------------------------
//   pix     | in  | valid/ready        | pixel[7:0]
//   feat    | out | valid/ready        | diff_right, diff_down, diff_diagonal,
//           |     |                    | anchor_row, anchor_col, last_of_frame
//   cfg     | in  | cfg_we (no ready)  | cfg_index (0 width, 1 height), cfg_data[6:0]
//
// One pixel per clock unless output stalls; results go to stage 1, then stage 2.
// The rate is set by the line buffer's one write and one read per cycle, which is read one
// pixel ahead: the address of the next pixel is known when the current one is accepted.
// Reset clears counters, window cells and valid flags; the line buffer is not cleared.
// A stalled result sits in the output register while one more window waits in stage 1;
// the pixel input stalls only when both are full.
`default_nettype none
module haar_2x2_feature_extractor_top (
	input  wire                              clk,
	input  wire                              arst_n,
	h2f_pixel_if.sink                        pix,
	h2f_feat_if.source                       feat,
	input  wire                              cfg_we,
	input  wire                              cfg_index,
	input  wire  [h2f_pkg::DIM_W-1:0]        cfg_data
);
	localparam int unsigned CW = h2f_pkg::CNT_W;
	localparam int unsigned DW = h2f_pkg::DIM_W;

	// configuration registers
	logic [DW-1:0] frame_width_q, frame_height_q;
	logic [DW-1:0] w_eff, h_eff;

	// raster position of the pixel about to be accepted
	logic [CW-1:0] col_q, row_q;
	logic [CW-1:0] col_nxt, row_nxt;
	logic          row_end, frame_end, produce;

	// stage 1: window in the cells plus its metadata; stage 2: output register
	logic          v_s1, v_s2;
	logic [CW-1:0] anc_row_s1, anc_col_s1;
	logic          last_s1;
	logic          in_acc, s2_load;

	logic [h2f_pkg::PIX_W-1:0] above_pix;
	h2f_pkg::pix_pair_t        cell_in  [h2f_pkg::WIN_COLS];
	h2f_pkg::pix_pair_t        cell_q   [h2f_pkg::WIN_COLS];

	// ---------------------------------------------------------------- config
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= h2f_pkg::WIDTH_RESET;
			frame_height_q <= h2f_pkg::HEIGHT_RESET;
		end else if (cfg_we) begin
			case (h2f_pkg::cfg_idx_t'(cfg_index))
				h2f_pkg::CFG_FRAME_WIDTH:  frame_width_q  <= cfg_data;
				h2f_pkg::CFG_FRAME_HEIGHT: frame_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// clamp width and height into 2..64
	always_comb begin
		if (frame_width_q < h2f_pkg::DIM_MIN) begin
			w_eff = h2f_pkg::DIM_MIN;
		end else if (frame_width_q > DW'(h2f_pkg::MAX_WIDTH)) begin
			w_eff = DW'(h2f_pkg::MAX_WIDTH);
		end else begin
			w_eff = frame_width_q;
		end
		if (frame_height_q < h2f_pkg::DIM_MIN) begin
			h_eff = h2f_pkg::DIM_MIN;
		end else if (frame_height_q > DW'(h2f_pkg::HEIGHT_LIMIT)) begin
			h_eff = DW'(h2f_pkg::HEIGHT_LIMIT);
		end else begin
			h_eff = frame_height_q;
		end
	end

	// ------------------------------------------------------------- handshake
	assign s2_load   = !v_s2 || feat.ready;
	assign pix.ready = !v_s1 || s2_load;
	assign in_acc    = pix.valid && pix.ready;

	// ---------------------------------------------------------- raster count
	always_comb begin
		row_end   = ({1'b0, col_q} + 7'd1) >= w_eff;
		frame_end = row_end && (({1'b0, row_q} + 7'd1) >= h_eff);
		produce   = (row_q != '0) && (col_q != '0);
		col_nxt   = row_end ? '0 : col_q + CW'(1);
		if (!row_end) begin
			row_nxt = row_q;
		end else if (frame_end) begin
			row_nxt = '0;
		end else begin
			row_nxt = row_q + CW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (in_acc) begin
			col_q <= col_nxt;
			row_q <= row_nxt;
		end
	end

	// ---------------------------------------------------------- line buffer
	// Write the new pixel at its column; fetch the next column's pixel of the row above.
	h2f_line_buf u_line_buf (
		.clk       (clk),
		.wr_en     (in_acc),
		.wr_addr   (col_q[h2f_pkg::ADDR_W-1:0]),
		.wr_data   (pix.pixel),
		.rd_en     (in_acc),
		.rd_addr   (col_nxt[h2f_pkg::ADDR_W-1:0]),
		.rd_data_q (above_pix)
	);

	// ---------------------------------------------------------- window cells
	// Cell 0 takes the new column (above, current); each later cell takes its neighbor.
	always_comb begin
		cell_in[0].top    = above_pix;
		cell_in[0].bottom = pix.pixel;
		for (int i = 1; i < h2f_pkg::WIN_COLS; i++) begin
			cell_in[i] = cell_q[i-1];
		end
	end

	for (genvar g = 0; g < h2f_pkg::WIN_COLS; g++) begin : g_cell
		h2f_col_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.advance (in_acc),
			.pair_in (cell_in[g]),
			.pair_q  (cell_q[g])
		);
	end

	// ---------------------------------------------------------------- stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_acc) begin
			v_s1 <= produce;
		end else if (s2_load) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			anc_row_s1 <= row_q - CW'(1);
			anc_col_s1 <= col_q - CW'(1);
			last_s1    <= frame_end;
		end
	end

	// ---------------------------------------------------------------- stage 2
	// a = top-left, b = top-right, c = bottom-left, d = bottom-right
	logic [9:0] pa, pb, pc, pd;
	always_comb begin
		pa = {2'b00, cell_q[1].top};
		pc = {2'b00, cell_q[1].bottom};
		pb = {2'b00, cell_q[0].top};
		pd = {2'b00, cell_q[0].bottom};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (s2_load) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_load && v_s1) begin
			feat.diff_right    <= 9'(pa - pb);
			feat.diff_down     <= 9'(pa - pc);
			feat.diff_diagonal <= (pa + pd) - (pb + pc);
			feat.anchor_row    <= anc_row_s1;
			feat.anchor_col    <= anc_col_s1;
			feat.last_of_frame <= last_s1;
		end
	end

	assign feat.valid = v_s2;

	// ------------------------------------------------------------- checks
	a_window_to_s1: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && produce |=> v_s1)
		else $error("window pixel accepted but stage 1 not loaded");

	a_s1_to_s2: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && s2_load |=> v_s2)
		else $error("stage 1 window lost on its way to the output");

	a_col_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && row_end |=> col_q == '0)
		else $error("column count did not wrap at row end");

	a_col_step: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && !row_end |=> col_q == $past(col_q) + CW'(1))
		else $error("column count did not advance");
endmodule
`default_nettype wire
